// File: rtl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types, command codes and helpers of the adaptive spike remover.
// ----------------------------------------------------------------------------
package asr_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FACTOR_W = 16;
    localparam int TOTAL_W  = 48;
    localparam int NUMBER_W = 24;
    localparam int MEAN_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 16;
    localparam int DIV_N_W  = 48;
    localparam int DIV_D_W  = 24;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd2560;
    localparam logic [NUMBER_W-1:0] NUMBER_MAX   = 24'hFFFFFF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [0:0] CFG_PEAK_FACTOR = 1'b0;
    localparam logic [0:0] CFG_FIX_MODE    = 1'b1;

    // fix status codes
    localparam logic [STATUS_W-1:0] FIX_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] FIX_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] FIX_FEW    = 2'd2;
    localparam logic [STATUS_W-1:0] FIX_NOGOOD = 2'd3;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE        = 5'd0;
    localparam t_op OP_LOAD        = 5'd1;
    localparam t_op OP_PUSH        = 5'd2;
    localparam t_op OP_INC         = 5'd3;
    localparam t_op OP_SUM_FIRST   = 5'd4;
    localparam t_op OP_SUM         = 5'd5;
    localparam t_op OP_SUM_END     = 5'd6;
    localparam t_op OP_MDIV        = 5'd7;
    localparam t_op OP_MEAN        = 5'd8;
    localparam t_op OP_SKIP_DEC    = 5'd9;
    localparam t_op OP_V0          = 5'd10;
    localparam t_op OP_DELTA       = 5'd11;
    localparam t_op OP_PEAK_FEW    = 5'd12;
    localparam t_op OP_PEAK_SEARCH = 5'd13;
    localparam t_op OP_ST_NOGOOD   = 5'd14;
    localparam t_op OP_GFOUND      = 5'd15;
    localparam t_op OP_FIXDONE     = 5'd16;
    localparam t_op OP_BLANK       = 5'd17;
    localparam t_op OP_IMUL        = 5'd18;
    localparam t_op OP_IDIV        = 5'd19;
    localparam t_op OP_IWRITE      = 5'd20;
    localparam t_op OP_ACC         = 5'd21;
    localparam t_op OP_EMIT        = 5'd22;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic run;
        logic full;
        logic skip_nz;
        logic rdv;
        logic last;
        logic at_g;
        logic good;
        logic over;
        logic total_nz;
        logic gt_mean;
        logic num_ok;
        logic few;
        logic blank_mode;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] d;
        d = $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
        return d[SAMPLE_W] ? SAMPLE_W'(-d) : SAMPLE_W'(d);
    endfunction

endpackage

// File: rtl/asr_div.sv
// ----------------------------------------------------------------------------
// asr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [asr_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [asr_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [asr_pkg::DIV_N_W-1:0]   o_quot
);
    import asr_pkg::*;

    localparam int CW = $clog2(DIV_N_W);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DIV_D_W:0] r_rem;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_div;

    logic [DIV_D_W+1:0] w_sh;
    logic [DIV_D_W+1:0] w_sub;

    assign w_sh  = {r_rem, r_q[DIV_N_W-1]};
    assign w_sub = w_sh - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_sub[DIV_D_W+1]) begin
                r_rem <= w_sub[DIV_D_W:0];
                r_q   <= {r_q[DIV_N_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DIV_D_W:0];
                r_q   <= {r_q[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/asr_ctrl.sv
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer of the spike remover: walks the window and drives the datapath.
// ----------------------------------------------------------------------------
module asr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  asr_pkg::t_dp_stat  i_stat,
    output asr_pkg::t_dp_cmd   o_cmd
);
    import asr_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_PUSH      = 5'd1;
    localparam logic [4:0] S_DECIDE    = 5'd2;
    localparam logic [4:0] S_SUM_FIRST = 5'd3;
    localparam logic [4:0] S_SUM       = 5'd4;
    localparam logic [4:0] S_SUM_END   = 5'd5;
    localparam logic [4:0] S_MDIV      = 5'd6;
    localparam logic [4:0] S_MDIVW     = 5'd7;
    localparam logic [4:0] S_CHK0      = 5'd8;
    localparam logic [4:0] S_FIND      = 5'd9;
    localparam logic [4:0] S_CMP       = 5'd10;
    localparam logic [4:0] S_GWAIT     = 5'd11;
    localparam logic [4:0] S_GOOD      = 5'd12;
    localparam logic [4:0] S_FWAIT     = 5'd13;
    localparam logic [4:0] S_FIX       = 5'd14;
    localparam logic [4:0] S_IDIV      = 5'd15;
    localparam logic [4:0] S_IDIVW     = 5'd16;
    localparam logic [4:0] S_FIN       = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (!i_stat.run) begin
                    if (i_stat.full) begin
                        o_cmd.op = OP_INC;
                        n_state  = S_SUM_FIRST;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_stat.skip_nz) begin
                    o_cmd.op = OP_SKIP_DEC;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_INC;
                    n_state  = S_CHK0;
                end
            end
            S_SUM_FIRST: begin
                o_cmd.op = OP_SUM_FIRST;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_stat.last) n_state = S_SUM_END;
            end
            S_SUM_END: begin
                o_cmd.op = OP_SUM_END;
                n_state  = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.op = OP_MDIV;
                n_state  = S_MDIVW;
            end
            S_MDIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_MEAN;
                    n_state  = S_FIN;
                end
            end
            S_CHK0: begin
                if (i_stat.rdv) begin
                    o_cmd.op = OP_V0;
                    n_state  = S_FIND;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIND: begin
                priority if (i_stat.rdv) begin
                    o_cmd.op = OP_DELTA;
                    n_state  = S_CMP;
                end else if (i_stat.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_INC;
                end
            end
            S_CMP: begin
                priority if (i_stat.total_nz && i_stat.over) begin
                    if (i_stat.few) begin
                        o_cmd.op = OP_PEAK_FEW;
                        n_state  = S_FIN;
                    end else begin
                        o_cmd.op = OP_PEAK_SEARCH;
                        n_state  = S_GWAIT;
                    end
                end else if (i_stat.gt_mean && i_stat.num_ok) begin
                    o_cmd.op = OP_ACC;
                    n_state  = S_MDIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_GWAIT: begin
                o_cmd.op = OP_INC;
                n_state  = S_GOOD;
            end
            S_GOOD: begin
                priority if (i_stat.good) begin
                    o_cmd.op = OP_GFOUND;
                    n_state  = S_FWAIT;
                end else if (i_stat.last) begin
                    o_cmd.op = OP_ST_NOGOOD;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_INC;
                end
            end
            S_FWAIT: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                priority if (i_stat.at_g) begin
                    o_cmd.op = OP_FIXDONE;
                    n_state  = S_FIN;
                end else if (!i_stat.rdv) begin
                    o_cmd.op = OP_INC;
                    n_state  = S_FWAIT;
                end else if (i_stat.blank_mode) begin
                    o_cmd.op = OP_BLANK;
                    n_state  = S_FWAIT;
                end else begin
                    o_cmd.op = OP_IMUL;
                    n_state  = S_IDIV;
                end
            end
            S_IDIV: begin
                o_cmd.op = OP_IDIV;
                n_state  = S_IDIVW;
            end
            S_IDIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_IWRITE;
                    n_state  = S_FWAIT;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDIV || r_state == S_IDIV) |=> !i_stat.div_done)
        else $error("divider finished right after start");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT) |-> i_stat.out_free)
        else $error("result emitted into a full output register");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |=> (r_state == S_PUSH))
        else $error("beat taken outside idle");

endmodule

// File: rtl/asr_dp.sv
// ----------------------------------------------------------------------------
// asr_dp
// Datapath: sample ring, delta statistics, threshold test, repair and
// output register.
// ----------------------------------------------------------------------------
module asr_dp #(
    parameter int WINDOW_DEPTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asr_pkg::t_dp_cmd              i_cmd,
    output asr_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [asr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [asr_pkg::SAMPLE_W-1:0]  i_s_axis_tdata,
    input  logic [0:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [asr_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,
    output logic [3:0]                    o_m_axis_tuser
);
    import asr_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int IW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int NW = SAMPLE_W + 2 + IW;

    // configuration
    logic [FACTOR_W-1:0] r_factor;
    logic                r_fix_mode;

    // ring
    logic [SAMPLE_W-1:0]     r_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_vld;
    logic [SAMPLE_W-1:0]     r_rd;
    logic                    r_rdv;

    // control state
    logic [AW-1:0]       r_ptr;
    logic [IW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_ridx;
    logic [IW-1:0]       r_skip;
    logic [IW-1:0]       r_g;
    logic                r_run;
    logic                r_out_full;

    // statistics and work registers
    logic [TOTAL_W-1:0]  r_total;
    logic [NUMBER_W-1:0] r_number;
    logic [MEAN_W-1:0]   r_mean;
    logic [TOTAL_W-1:0]  r_acc;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] r_v0;
    logic [SAMPLE_W-1:0] r_delta;
    logic [TOTAL_W-1:0]  r_prod;
    logic [SAMPLE_W:0]   r_diff;
    logic [NW-1:0]       r_num;
    logic                r_neg;

    // input latch and result
    logic [SAMPLE_W-1:0] r_in_value;
    logic                r_in_ok;
    logic [SAMPLE_W-1:0] r_res_value;
    logic                r_res_valid;
    logic                r_res_peak;
    logic [STATUS_W-1:0] r_res_status;
    logic [SAMPLE_W-1:0] r_out_value;
    logic [3:0]          r_out_user;

    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic [SAMPLE_W-1:0] w_sdelta;
    logic [SAMPLE_W-1:0] w_gdelta;
    logic [TOTAL_W:0]    w_acc_sum;
    logic [TOTAL_W:0]    w_tot_sum;
    logic [NW-1:0]       w_nmag;
    logic [NW-1:0]       w_q;
    logic [NW-1:0]       w_ival;
    logic                w_div_start;
    logic [DIV_N_W-1:0]  w_div_n;
    logic [DIV_D_W-1:0]  w_div_d;
    logic                w_div_busy;
    logic                w_div_done;
    logic [DIV_N_W-1:0]  w_quot;
    logic [IW-1:0]       w_cnt_dec;

    function automatic logic [AW-1:0] at_addr(input logic [AW-1:0] ptr,
                                              input logic [IW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(ptr) + SW'(idx);
        if (s >= SW'(WINDOW_DEPTH)) s = s - SW'(WINDOW_DEPTH);
        return s[AW-1:0];
    endfunction

    assign w_raddr   = at_addr(r_ptr, r_idx);
    assign w_waddr   = at_addr(r_ptr, r_ridx);
    assign w_sdelta  = absdiff(r_rd, r_prev);
    assign w_gdelta  = absdiff(r_rd, r_v0);
    assign w_acc_sum = {1'b0, r_acc} + (TOTAL_W + 1)'(w_sdelta);
    assign w_tot_sum = {1'b0, r_total} + (TOTAL_W + 1)'(r_delta);
    assign w_nmag    = r_num[NW-1] ? -r_num : r_num;
    assign w_q       = r_neg ? -w_quot[NW-1:0] : w_quot[NW-1:0];
    assign w_ival    = {{(NW - SAMPLE_W){r_v0[SAMPLE_W-1]}}, r_v0} + w_q;
    assign w_cnt_dec = (r_count != '0) ? r_count - 1'b1 : r_count;

    assign w_div_start = (i_cmd.op == OP_MDIV) || (i_cmd.op == OP_IDIV);
    assign w_div_n     = (i_cmd.op == OP_IDIV) ? {{(DIV_N_W - NW){1'b0}}, w_nmag} : r_total;
    assign w_div_d     = (i_cmd.op == OP_IDIV) ? DIV_D_W'(r_g) : r_number;

    asr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PUSH) begin
            r_mem[r_ptr] <= r_in_value;
        end else if (i_cmd.op == OP_IWRITE) begin
            r_mem[w_waddr] <= w_ival[SAMPLE_W-1:0];
        end
        r_rd <= r_mem[w_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor   <= FACTOR_RESET;
            r_fix_mode <= 1'b0;
            r_vld      <= '0;
            r_rdv      <= 1'b0;
            r_ptr      <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_ridx     <= '0;
            r_skip     <= '0;
            r_g        <= '0;
            r_run      <= 1'b0;
            r_out_full <= 1'b0;
            r_total    <= '0;
            r_number   <= '0;
            r_mean     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_PEAK_FACTOR: r_factor   <= i_cfg_wdata;
                    CFG_FIX_MODE:    r_fix_mode <= i_cfg_wdata[0];
                    default:         r_factor   <= r_factor;
                endcase
            end
            r_rdv  <= r_vld[w_raddr];
            r_ridx <= r_idx;
            if (r_out_full && i_m_axis_tready && (i_cmd.op != OP_EMIT)) r_out_full <= 1'b0;
            unique case (i_cmd.op)
                OP_PUSH: begin
                    r_vld[r_ptr] <= r_in_ok;
                    r_count <= ((r_rdv) ? w_cnt_dec : r_count) + IW'(r_in_ok);
                    r_ptr   <= (r_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                end
                OP_INC, OP_SUM_FIRST, OP_SUM, OP_V0: begin
                    if (r_idx != IW'(WINDOW_DEPTH)) r_idx <= r_idx + 1'b1;
                end
                OP_SUM_END: begin
                    r_total  <= r_acc;
                    r_number <= NUMBER_W'(WINDOW_DEPTH - 1);
                    r_run    <= 1'b1;
                end
                OP_MEAN: begin
                    r_mean <= w_quot[MEAN_W-1:0];
                end
                OP_SKIP_DEC: begin
                    r_skip <= r_skip - 1'b1;
                end
                OP_PEAK_SEARCH: begin
                    r_idx <= IW'(2);
                end
                OP_GFOUND: begin
                    r_g   <= r_ridx;
                    r_idx <= IW'(1);
                end
                OP_FIXDONE: begin
                    r_skip <= r_g;
                end
                OP_BLANK: begin
                    r_vld[w_waddr] <= 1'b0;
                    r_count <= w_cnt_dec;
                    r_idx   <= r_idx + 1'b1;
                end
                OP_IWRITE: begin
                    r_idx <= r_idx + 1'b1;
                end
                OP_ACC: begin
                    r_number <= r_number + 1'b1;
                    r_total  <= w_tot_sum[TOTAL_W] ? TOTAL_MAX : w_tot_sum[TOTAL_W-1:0];
                end
                OP_EMIT: begin
                    r_idx      <= '0;
                    r_out_full <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_in_value <= i_s_axis_tuser[0] ? i_s_axis_tdata : '0;
                r_in_ok    <= i_s_axis_tuser[0];
            end
            OP_PUSH: begin
                r_res_value  <= r_rdv ? r_rd : '0;
                r_res_valid  <= r_rdv;
                r_res_peak   <= 1'b0;
                r_res_status <= FIX_NONE;
            end
            OP_SUM_FIRST: begin
                r_prev <= r_rd;
                r_acc  <= '0;
            end
            OP_SUM: begin
                r_prev <= r_rd;
                r_acc  <= w_acc_sum[TOTAL_W] ? TOTAL_MAX : w_acc_sum[TOTAL_W-1:0];
            end
            OP_V0: begin
                r_v0   <= r_rd;
                r_prod <= TOTAL_W'(r_factor) * TOTAL_W'(r_mean);
            end
            OP_DELTA: begin
                r_delta <= w_gdelta;
            end
            OP_PEAK_FEW: begin
                r_res_peak   <= 1'b1;
                r_res_status <= FIX_FEW;
            end
            OP_PEAK_SEARCH: begin
                r_res_peak <= 1'b1;
            end
            OP_ST_NOGOOD: begin
                r_res_status <= FIX_NOGOOD;
            end
            OP_GFOUND: begin
                r_diff <= {r_rd[SAMPLE_W-1], r_rd} - {r_v0[SAMPLE_W-1], r_v0};
            end
            OP_FIXDONE: begin
                r_res_status <= FIX_DONE;
            end
            OP_IMUL: begin
                r_num <= $signed({{(NW - IW){1'b0}}, r_ridx})
                       * $signed({{(NW - SAMPLE_W - 1){r_diff[SAMPLE_W]}}, r_diff});
            end
            OP_IDIV: begin
                r_neg <= r_num[NW-1];
            end
            OP_EMIT: begin
                r_out_value <= r_res_value;
                r_out_user  <= {r_res_status, r_res_peak, r_res_valid};
            end
            default: begin
            end
        endcase
    end

    assign o_stat.run        = r_run;
    assign o_stat.full       = (r_count >= IW'(WINDOW_DEPTH));
    assign o_stat.skip_nz    = (r_skip != '0);
    assign o_stat.rdv        = r_rdv;
    assign o_stat.last       = (r_ridx == IW'(WINDOW_DEPTH - 1));
    assign o_stat.at_g       = (r_ridx == r_g);
    assign o_stat.good       = r_rdv && !({8'b0, w_gdelta, 8'b0} > r_prod);
    assign o_stat.over       = ({8'b0, r_delta, 8'b0} > r_prod);
    assign o_stat.total_nz   = (r_total != '0);
    assign o_stat.gt_mean    = (r_delta > r_mean);
    assign o_stat.num_ok     = (r_number != NUMBER_MAX);
    assign o_stat.few        = (r_count <= IW'(2));
    assign o_stat.blank_mode = r_fix_mode;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_free   = !r_out_full || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_full;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_user;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(WINDOW_DEPTH))
        else $error("valid count above window depth");

    a_run_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |=> r_run)
        else $error("run phase left");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_skip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip < IW'(WINDOW_DEPTH))
        else $error("skip count out of range");

endmodule

// File: rtl/adaptive_spike_remover.sv
// ----------------------------------------------------------------------------
// adaptive_spike_remover
// Ring window spike detector with interpolation or blanking of outliers.
//
//  channel   dir  tdata             tuser
//  s_axis    in   sample_value      [0] sample_valid
//  m_axis    out  out_value         [0] out_valid [1] peak_found [3:2] fix_status
//  cfg       in   0 peak_factor, 1 fix_mode (write only)
//
// one beat in, one beat out; a beat is accepted only in idle, so each push runs
// to completion before the next ready: an unchecked push is shortest, a checked push
// walks past no-data entries, the start-up push walks the whole window, and growth
// of the mean and each interpolated point also wait on the divider, all on top of
// the window walk.
// synchronous active-low reset clears the window to no-data at once.
// a new beat is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
module adaptive_spike_remover #(
    parameter int WINDOW_DEPTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [asr_pkg::SAMPLE_W-1:0]  i_s_axis_tdata,  // sample_value
    input  logic [0:0]                    i_s_axis_tuser,  // sample_valid
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [asr_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,  // out_value
    output logic [3:0]                    o_m_axis_tuser,  // out_valid, peak_found, fix_status
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [asr_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import asr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    asr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    asr_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive spike remover. A scoreboard class
// mirrors the window, the delta statistics and the repair logic, and checks
// every output beat in order. Directed pushes come first. Random traffic
// follows: mostly smooth sample runs with spikes, gaps and full-range noise,
// under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------

module tb_top;
    import asr_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
        logic        peak;
        logic [1:0]  status;
    } t_out_beat;

    class spike_scoreboard;
        localparam int DEPTH = 12;
        localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF;
        localparam int unsigned NMAX = 32'hFF_FFFF;

        logic [31:0]     ring_val[DEPTH];
        bit              ring_ok[DEPTH];
        int unsigned     ptr, vcnt, skip, dnum;
        longint unsigned dtotal;
        longint unsigned dmean;
        bit              running;
        longint unsigned factor;
        bit              blank_mode;
        t_out_beat       pending[$];
        int              errors;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                ring_val[i] = '0;
                ring_ok[i] = 0;
            end
            ptr = 0; vcnt = 0; skip = 0; dnum = 0;
            dtotal = 0; dmean = 0; running = 0;
            factor = FACTOR_RESET; blank_mode = 0; errors = 0;
        endfunction

        function void set_cfg(logic [0:0] addr, logic [15:0] data);
            if (addr == CFG_PEAK_FACTOR) factor = data;
            else blank_mode = data[0];
        endfunction

        function int idx(int i);
            return (ptr + i) % DEPTH;
        endfunction

        function longint unsigned adiff(logic [31:0] a, logic [31:0] b);
            longint d;
            d = longint'($signed(a)) - longint'($signed(b));
            return d < 0 ? -d : d;
        endfunction

        function bit over(longint unsigned delta);
            return (delta << 8) > factor * dmean;
        endfunction

        function logic [1:0] repair();
            int g;
            longint v0, diff, q;
            if (vcnt <= 2) return FIX_FEW;
            g = 2;
            while (g < DEPTH && (!ring_ok[idx(g)] ||
                   over(adiff(ring_val[idx(g)], ring_val[idx(0)]))))
                g++;
            if (g >= DEPTH) return FIX_NOGOOD;
            v0 = $signed(ring_val[idx(0)]);
            diff = longint'($signed(ring_val[idx(g)])) - v0;
            for (int i = 1; i < g; i++) begin
                if (!ring_ok[idx(i)]) continue;
                if (blank_mode) begin
                    ring_ok[idx(i)] = 0;
                    ring_val[idx(i)] = '0;
                    if (vcnt > 0) vcnt--;
                end else begin
                    q = (longint'(i) * diff) / longint'(g);
                    ring_val[idx(i)] = 32'(v0 + q);
                end
            end
            skip = g;
            return FIX_DONE;
        endfunction

        function void note_input(logic [31:0] v, logic ok);
            t_out_beat r;
            int c;
            longint unsigned s, delta;
            r.valid = ring_ok[ptr];
            r.value = ring_ok[ptr] ? ring_val[ptr] : '0;
            r.peak = 0;
            r.status = FIX_NONE;
            if (ring_ok[ptr] && vcnt > 0) vcnt--;
            if (ok) vcnt++;
            ring_val[ptr] = ok ? v : '0;
            ring_ok[ptr] = ok;
            ptr = (ptr + 1) % DEPTH;
            if (!running) begin
                if (vcnt >= DEPTH) begin
                    s = 0;
                    for (int i = 0; i + 1 < DEPTH; i++)
                        s += adiff(ring_val[idx(i)], ring_val[idx(i + 1)]);
                    dtotal = s > TMAX ? TMAX : s;
                    dnum = DEPTH - 1;
                    dmean = (dtotal / dnum) & 64'hFFFF_FFFF;
                    running = 1;
                end
            end else if (skip > 0) begin
                skip--;
            end else if (ring_ok[idx(0)]) begin
                c = 1;
                while (c < DEPTH && !ring_ok[idx(c)]) c++;
                if (c < DEPTH) begin
                    delta = adiff(ring_val[idx(c)], ring_val[idx(0)]);
                    if (dtotal > 0 && over(delta)) begin
                        r.peak = 1;
                        r.status = repair();
                    end else if (delta > dmean && dnum < NMAX) begin
                        dnum++;
                        dtotal += delta;
                        if (dtotal > TMAX) dtotal = TMAX;
                        dmean = (dtotal / dnum) & 64'hFFFF_FFFF;
                    end
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [31:0] data, logic [3:0] user);
            t_out_beat e, a;
            a.value = data; a.valid = user[0]; a.peak = user[1]; a.status = user[3:2];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h %b", data, user);
                return;
            end
            e = pending.pop_front();
            if (e !== a) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp val %h ok %b pk %b st %0d, got val %h ok %b pk %b st %0d",
                             e.value, e.valid, e.peak, e.status,
                             a.value, a.valid, a.peak, a.status);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;   // [0] sample_valid
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [31:0] o_m_axis_tdata;        // out_value
    logic [3:0]  o_m_axis_tuser;        // [0] out_valid [1] peak_found [3:2] fix_status
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    spike_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_req = 0;
    longint level = 0;
    int  stall_cycles = 0;

    adaptive_spike_remover uut (.*);

    always #6 i_clk = ~i_clk;

    task automatic send_sample(logic [31:0] v, logic ok);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= v;
        i_s_axis_tuser <= ok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(v, ok);
    endtask

    task automatic write_cfg(logic [0:0] addr, logic [15:0] data);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_cfg(addr, data);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_sample();
        int r;
        longint off;
        r = $urandom_range(99);
        if (r < 84) begin
            off = $urandom_range(1 << $urandom_range(4, 16));
            level = $urandom_range(1) ? level + off : level - off;
            if (level > 64'sd1073741824 || level < -64'sd1073741824) level = 0;
            send_sample(32'(level), 1);
        end else if (r < 88) begin
            off = $urandom_range(1 << 20, 1 << 28);
            send_sample(32'($urandom_range(1) ? level + off : level - off), 1);
        end else if (r < 93) begin
            send_sample($urandom(), 0);
        end else begin
            send_sample($urandom(), 1'($urandom_range(1)));
        end
    endtask

    // receiver
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (hold_req) begin
                i_m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= 20000) begin
                $display("FAIL adaptive_spike_remover");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] factors[6];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: fill, spike, gaps, extremes
        for (int i = 0; i < 12; i++) send_sample(32'(i * 100), 1);
        send_sample(32'd5_000_000, 1);
        send_sample(32'd1300, 1);
        send_sample(32'd1400, 0);
        send_sample(32'd1500, 1);
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(32'h8000_0000, 1);
        send_sample(32'd0, 1);
        send_sample(32'hFFFF_FFFF, 1);
        send_sample(32'd1600, 1);
        send_sample(32'd1700, 1);
        drain();

        factors = '{16'd512, 16'd65535, 16'd2560, 16'($urandom_range(512, 4000)), 16'd512,
                    16'($urandom_range(512, 65535))};
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_PEAK_FACTOR, factors[ph]);
            write_cfg(CFG_FIX_MODE, 16'(ph % 2));
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            for (int n = 0; n < 130; n++) begin
                if (ph == 0 && n == 40) hold_req = 1;
                random_sample();
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS adaptive_spike_remover");
        end else begin
            $display("FAIL adaptive_spike_remover");
        end
        $finish;
    end
endmodule
